/* hdl/uwsp_pkg.sv */
// Package for the unit-weight shortest path engine.
// Holds the shared constants, command codes and controller/datapath structs.
// No dependencies.
package uwsp_pkg;

    // Graph size and field widths.
    localparam int NV    = 16;
    localparam int VTX_W = 4;
    localparam int CNT_W = 5;
    localparam int CMD_W = 2;

    // Input command codes; the fourth code is unused and ignored.
    typedef enum logic [CMD_W-1:0] {
        CMD_SET_EDGE = 2'd0,
        CMD_CLR_EDGE = 2'd1,
        CMD_QUERY    = 2'd2
    } t_cmd;

    // One word of the per-vertex store: distance with its valid bit and
    // predecessor with its valid bit.
    typedef struct packed {
        logic             dvalid;
        logic [VTX_W-1:0] hops;
        logic             pvalid;
        logic [VTX_W-1:0] pred;
    } t_node;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic init_wr;
        logic row_rd;
        logic row_latch;
        logic col_step;
        logic emit;
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_query;
        logic range_ok;
        logic init_last;
        logic n_le1;
        logic row_skip;
        logic col_last;
        logic row_last;
        logic pass_last;
        logic out_free;
        logic item_last;
    } t_sts;

endpackage

/* hdl/uwsp_cmd_if.sv */
// Command channel interface: one beat carries one edge command or query.
// Depends on uwsp_pkg.
interface uwsp_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [uwsp_pkg::CMD_W-1:0]    cmd;
    logic [uwsp_pkg::VTX_W-1:0]    src_vertex;
    logic [uwsp_pkg::VTX_W-1:0]    dst_vertex;

    modport source (output valid, cmd, src_vertex, dst_vertex, input ready);
    modport sink   (input valid, cmd, src_vertex, dst_vertex, output ready);
endinterface

/* hdl/uwsp_res_if.sv */
// Result channel interface: one beat carries one vertex of a query answer.
// Depends on uwsp_pkg.
interface uwsp_res_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [uwsp_pkg::VTX_W-1:0]    distance;
    logic [uwsp_pkg::VTX_W-1:0]    path_vertex;
    logic                          last;

    modport source (output valid, found, distance, path_vertex, last, input ready);
    modport sink   (input valid, found, distance, path_vertex, last, output ready);
endinterface

/* hdl/uwsp_cfg_if.sv */
// Configuration write channel interface: one beat writes vertex_count.
// Depends on uwsp_pkg.
interface uwsp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [uwsp_pkg::CNT_W-1:0]    vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink   (input valid, vertex_count, output ready);
endinterface

/* hdl/uwsp_datapath.sv */
// Datapath of the shortest path engine: adjacency matrix, vertex store,
// loop counters and the result register. Depends on uwsp_pkg.
module uwsp_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  uwsp_pkg::t_ctl              i_ctl,
    output uwsp_pkg::t_sts              o_sts,
    input  logic [uwsp_pkg::CMD_W-1:0]  i_cmd,
    input  logic [uwsp_pkg::VTX_W-1:0]  i_src,
    input  logic [uwsp_pkg::VTX_W-1:0]  i_dst,
    input  logic                        i_cfg_wr,
    input  logic [uwsp_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_found,
    output logic [uwsp_pkg::VTX_W-1:0]  o_distance,
    output logic [uwsp_pkg::VTX_W-1:0]  o_path_vertex,
    output logic                        o_last
);

    logic [uwsp_pkg::CNT_W-1:0]  r_vcount;
    logic [uwsp_pkg::CNT_W-1:0]  n_act;
    logic [uwsp_pkg::VTX_W-1:0]  last_idx;
    logic [uwsp_pkg::NV-1:0]     vmask;
    logic [uwsp_pkg::NV-1:0]     r_adj [uwsp_pkg::NV];
    uwsp_pkg::t_node             r_mem [uwsp_pkg::NV];
    uwsp_pkg::t_node             r_rd;
    uwsp_pkg::t_node             wr_data;
    logic [uwsp_pkg::VTX_W-1:0]  rd_addr;
    logic                        mem_we;
    logic [uwsp_pkg::VTX_W-1:0]  r_src;
    logic [uwsp_pkg::VTX_W-1:0]  r_v;
    logic                        r_nf;
    logic [uwsp_pkg::VTX_W-1:0]  r_i;
    logic [uwsp_pkg::VTX_W-1:0]  r_j;
    logic [uwsp_pkg::VTX_W-1:0]  r_k;
    logic [uwsp_pkg::VTX_W-1:0]  r_cnt;
    logic [uwsp_pkg::VTX_W-1:0]  r_dist_e;
    logic [uwsp_pkg::VTX_W-1:0]  r_row_dist;
    logic [uwsp_pkg::NV-1:0]     r_adj_row;
    logic [uwsp_pkg::CNT_W-1:0]  sum;
    logic                        relax;
    logic                        row_adv;
    logic                        is_edge;
    logic                        item_found;
    logic                        r_out_valid;
    logic                        r_found;
    logic [uwsp_pkg::VTX_W-1:0]  r_distance;
    logic [uwsp_pkg::VTX_W-1:0]  r_path;
    logic                        r_last;
    uwsp_pkg::t_cmd              cmd;

    // Effective vertex count, clamped to the matrix size, and its column mask.
    always_comb begin
        n_act = (r_vcount > uwsp_pkg::CNT_W'(uwsp_pkg::NV)) ?
                uwsp_pkg::CNT_W'(uwsp_pkg::NV) : r_vcount;
        last_idx = uwsp_pkg::VTX_W'(n_act - uwsp_pkg::CNT_W'(1));
        for (int b = 0; b < uwsp_pkg::NV; b++) begin
            vmask[b] = (uwsp_pkg::CNT_W'(b) < n_act);
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
        end else if (i_cfg_wr) begin
            r_vcount <= i_cfg_data;
        end
    end

    // Command decode.
    assign cmd     = uwsp_pkg::t_cmd'(i_cmd);
    assign is_edge = (cmd == uwsp_pkg::CMD_SET_EDGE) || (cmd == uwsp_pkg::CMD_CLR_EDGE);

    // Adjacency matrix: edge commands with both vertices in range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < uwsp_pkg::NV; r++) begin
                r_adj[r] <= '0;
            end
        end else if (i_ctl.accept && is_edge && o_sts.range_ok) begin
            r_adj[i_src][i_dst] <= (cmd == uwsp_pkg::CMD_SET_EDGE);
        end
    end

    // Relaxation of edge (i, j) against the latched row distance.
    assign sum   = {1'b0, r_row_dist} + uwsp_pkg::CNT_W'(1);
    assign relax = r_adj_row[r_j] && (!r_rd.dvalid || (sum < {1'b0, r_rd.hops}));

    // Vertex store write port: the clearing sweep or a relaxation.
    always_comb begin
        mem_we  = 1'b0;
        wr_data = '0;
        if (i_ctl.init_wr) begin
            mem_we         = 1'b1;
            wr_data.dvalid = (r_j == r_src);
        end else if (i_ctl.col_step && relax) begin
            mem_we         = 1'b1;
            wr_data.dvalid = 1'b1;
            wr_data.hops   = sum[uwsp_pkg::VTX_W-1:0];
            wr_data.pvalid = 1'b1;
            wr_data.pred   = r_i;
        end
    end

    // Vertex store read address.
    always_comb begin
        if (i_ctl.row_rd) begin
            rd_addr = r_i;
        end else if (i_ctl.row_latch) begin
            rd_addr = '0;
        end else if (i_ctl.col_step) begin
            rd_addr = r_j + uwsp_pkg::VTX_W'(1);
        end else begin
            rd_addr = r_v;
        end
    end

    // Vertex store with registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_j] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // A row ends after its last column or when it cannot relax anything.
    assign row_adv = (i_ctl.row_latch && o_sts.row_skip) || (i_ctl.col_step && o_sts.col_last);

    // Loop counters and query registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && o_sts.is_query) begin
            r_src <= i_src;
            r_v   <= i_dst;
            r_nf  <= !o_sts.range_ok;
            r_i   <= '0;
            r_j   <= '0;
            r_k   <= uwsp_pkg::VTX_W'(1);
            r_cnt <= '0;
        end else begin
            if (i_ctl.init_wr || i_ctl.col_step) begin
                r_j <= r_j + uwsp_pkg::VTX_W'(1);
            end
            if (i_ctl.row_latch) begin
                r_row_dist <= r_rd.hops;
                r_adj_row  <= r_adj[r_i] & vmask;
                r_j        <= '0;
            end
            if (row_adv) begin
                if (o_sts.row_last) begin
                    r_i <= '0;
                    r_k <= r_k + uwsp_pkg::VTX_W'(1);
                end else begin
                    r_i <= r_i + uwsp_pkg::VTX_W'(1);
                end
            end
            if (i_ctl.emit) begin
                r_v   <= r_rd.pred;
                r_cnt <= r_cnt + uwsp_pkg::VTX_W'(1);
                if (r_cnt == '0) begin
                    r_dist_e <= r_rd.hops;
                end
            end
        end
    end

    // Fields of the next result beat.
    assign item_found = !r_nf && r_rd.dvalid;

    // Result register: holds one beat until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_found    <= item_found;
            r_distance <= !item_found ? '0 : ((r_cnt == '0) ? r_rd.hops : r_dist_e);
            r_path     <= item_found ? r_v : '0;
            r_last     <= o_sts.item_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_distance    = r_distance;
    assign o_path_vertex = r_path;
    assign o_last        = r_last;

    // Status to the controller.
    always_comb begin
        o_sts.is_query  = (cmd == uwsp_pkg::CMD_QUERY);
        o_sts.range_ok  = ({1'b0, i_src} < n_act) && ({1'b0, i_dst} < n_act);
        o_sts.init_last = (r_j == last_idx);
        o_sts.n_le1     = (n_act <= uwsp_pkg::CNT_W'(1));
        o_sts.row_skip  = !r_rd.dvalid || ((r_adj[r_i] & vmask) == '0);
        o_sts.col_last  = (r_j == last_idx);
        o_sts.row_last  = (r_i == last_idx);
        o_sts.pass_last = (r_k == last_idx);
        o_sts.out_free  = !r_out_valid || i_out_ready;
        o_sts.item_last = !item_found || !r_rd.pvalid || (r_cnt == '1);
    end

endmodule

/* hdl/uwsp_ctrl.sv */
// Controller state machine of the shortest path engine.
// Sequences clearing, relaxation passes and the path walk. Depends on uwsp_pkg.
module uwsp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  uwsp_pkg::t_sts  i_sts,
    output uwsp_pkg::t_ctl  o_ctl
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_INIT      = 7'b0000010,
        S_ROW_RD    = 7'b0000100,
        S_ROW_LATCH = 7'b0001000,
        S_COL       = 7'b0010000,
        S_WALK_RD   = 7'b0100000,
        S_EMIT      = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state row_done_state;

    // After the last row of the last pass the walk starts.
    assign row_done_state = (i_sts.row_last && i_sts.pass_last) ? S_WALK_RD : S_ROW_RD;

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_ctl.accept = i_in_valid;
                if (i_in_valid && i_sts.is_query) begin
                    n_state = i_sts.range_ok ? S_INIT : S_EMIT;
                end
            end
            S_INIT: begin
                o_ctl.init_wr = 1'b1;
                if (i_sts.init_last) begin
                    n_state = i_sts.n_le1 ? S_WALK_RD : S_ROW_RD;
                end
            end
            S_ROW_RD: begin
                o_ctl.row_rd = 1'b1;
                n_state      = S_ROW_LATCH;
            end
            S_ROW_LATCH: begin
                o_ctl.row_latch = 1'b1;
                n_state         = i_sts.row_skip ? row_done_state : S_COL;
            end
            S_COL: begin
                o_ctl.col_step = 1'b1;
                if (i_sts.col_last) begin
                    n_state = row_done_state;
                end
            end
            S_WALK_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    n_state    = i_sts.item_last ? S_IDLE : S_WALK_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hdl/unit_weight_shortest_path.sv */
// Top level of the unit-weight shortest path engine.
// Depends on uwsp_pkg, the channel interfaces, uwsp_ctrl and uwsp_datapath.
//
//  Channel    Dir  Beat carries
//  i_cmd_ch   in   cmd, src_vertex, dst_vertex
//  o_res_ch   out  found, distance, path_vertex, last
//  i_cfg_ch   in   vertex_count
//
// An edge command is applied as it is accepted. A query with n active vertices
// first clears the vertex store, then runs n-1 passes of n rows; a row reads
// and latches its vertex, then steps through n columns, or skips them when its
// vertex is unreached or it has no edges. Each path beat reads its vertex and
// waits out any output stall; an out-of-range query goes straight to one beat.
// Reset clears the matrix, the vertex count and the controller; commands are
// taken only while the engine is idle, the result register holds a stalled beat.
module unit_weight_shortest_path (
    input  logic         i_clk,
    input  logic         i_rst_n,
    uwsp_cmd_if.sink     i_cmd_ch,
    uwsp_res_if.source   o_res_ch,
    uwsp_cfg_if.sink     i_cfg_ch
);

    uwsp_pkg::t_ctl ctl;
    uwsp_pkg::t_sts sts;

    // Configuration writes are always taken.
    assign i_cfg_ch.ready = 1'b1;

    uwsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd_ch.valid),
        .o_in_ready (i_cmd_ch.ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    uwsp_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_cmd         (i_cmd_ch.cmd),
        .i_src         (i_cmd_ch.src_vertex),
        .i_dst         (i_cmd_ch.dst_vertex),
        .i_cfg_wr      (i_cfg_ch.valid),
        .i_cfg_data    (i_cfg_ch.vertex_count),
        .i_out_ready   (o_res_ch.ready),
        .o_out_valid   (o_res_ch.valid),
        .o_found       (o_res_ch.found),
        .o_distance    (o_res_ch.distance),
        .o_path_vertex (o_res_ch.path_vertex),
        .o_last        (o_res_ch.last)
    );

endmodule
